// ===== rtl/two_ended_first_fit_allocator_top_assert.svh =====
// Assertion macros for the two-ended first-fit allocator checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef TWO_ENDED_FIRST_FIT_ALLOCATOR_TOP_ASSERT_SVH
`define TWO_ENDED_FIRST_FIT_ALLOCATOR_TOP_ASSERT_SVH

// Checked only while reset is released.
`define TEFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TEFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tefa_pkg.sv =====
// Shared types, codes and constants of the two-ended first-fit allocator.
// No dependencies; every other file but the assertion header imports this package.
`default_nettype none
package tefa_pkg;

  localparam int DEF_ARENA_BYTES  = 4096;
  localparam int DEF_HEADER_BYTES = 16;
  localparam int CALC_W           = 18;
  localparam logic [11:0] THRESHOLD_RESET = 12'd100;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_OUT_BOUND = 3'd2;
  localparam logic [2:0] ST_DBL_FREE  = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

  typedef struct packed {
    logic        action;
    logic [15:0] operand_value;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload_offset;
  } out_rsp_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR_STEP, OP_LATCH, OP_INIT_ARENA, OP_SMALL_START, OP_RD_MID,
    OP_UP_START, OP_DOWN_START, OP_RD_W, OP_STEP_UP, OP_STEP_DOWN,
    OP_SETUP_SMALL, OP_SETUP_UP, OP_SETUP_DOWN, OP_PH_INIT, OP_PH_STEP,
    OP_G_T, OP_G_W, OP_G_NOSPLIT, OP_NOSPACE, OP_F_OOB, OP_F_RD_H,
    OP_F_NOTALLOC, OP_F_DBL, OP_F_SET, OP_F_RD_Q, OP_F_MERGE_Q, OP_F_RD_N,
    OP_F_MERGE_N
  } op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_A_START, S_A_SEL, S_U_GO,
    S_RD_S, S_EV_S, S_RD_U, S_EV_U, S_RD_D, S_EV_D,
    S_G_DEC, S_PH, S_G_T, S_G_W, S_NOSPACE,
    S_F_CHK, S_F_EVH, S_F_Q, S_F_EVQ, S_F_N, S_F_EVN, S_DONE
  } state_t;

  typedef struct packed {
    logic clr_last;
    logic ready;
    logic act;
    logic is_small;
    logic w_end;
    logic fit;
    logic split;
    logic ph_last;
    logic free_bad;
    logic mark;
    logic free;
    logic pv_ok;
    logic nx_ok;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/tefa_ctrl.sv =====
// Sequencer of the allocator: walks the block list and issues one datapath
// operation per cycle. Depends on tefa_pkg.
`default_nettype none
module tefa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire tefa_pkg::stat_t stat,
  output tefa_pkg::op_t        op,
  output logic                 busy,
  output logic                 out_valid
);
  import tefa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (start) state_nxt = S_DISPATCH;
      S_DISPATCH: state_nxt = stat.act ? S_F_CHK : S_A_START;
      S_A_START:  state_nxt = S_A_SEL;
      S_A_SEL:    state_nxt = stat.is_small ? S_RD_S : S_U_GO;
      S_U_GO:     state_nxt = S_RD_U;
      S_RD_S:     state_nxt = stat.w_end ? S_NOSPACE : S_EV_S;
      S_EV_S:     state_nxt = stat.fit ? S_G_DEC : S_RD_S;
      S_RD_U:     state_nxt = stat.w_end ? S_RD_D : S_EV_U;
      S_EV_U:     state_nxt = stat.fit ? S_G_DEC : S_RD_U;
      S_RD_D:     state_nxt = stat.w_end ? S_NOSPACE : S_EV_D;
      S_EV_D:     state_nxt = stat.fit ? S_G_DEC : S_RD_D;
      S_G_DEC:    state_nxt = stat.split ? S_PH : S_DONE;
      S_PH:       if (stat.ph_last) state_nxt = S_G_T;
      S_G_T:      state_nxt = S_G_W;
      S_G_W:      state_nxt = S_DONE;
      S_NOSPACE:  state_nxt = S_DONE;
      S_F_CHK:    state_nxt = stat.free_bad ? S_DONE : S_F_EVH;
      S_F_EVH:    state_nxt = (!stat.mark || stat.free) ? S_DONE : S_F_Q;
      S_F_Q:      state_nxt = stat.pv_ok ? S_F_EVQ : S_F_N;
      S_F_EVQ:    state_nxt = S_F_N;
      S_F_N:      state_nxt = stat.nx_ok ? S_F_EVN : S_DONE;
      S_F_EVN:    state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    op        = OP_NONE;
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    case (state_r)
      S_CLEAR:   op = OP_CLR_STEP;
      S_IDLE:    if (start) op = OP_LATCH;
      S_A_START: if (!stat.ready) op = OP_INIT_ARENA;
      S_A_SEL:   op = stat.is_small ? OP_SMALL_START : OP_RD_MID;
      S_U_GO:    op = OP_UP_START;
      S_RD_S:    if (!stat.w_end) op = OP_RD_W;
      S_RD_U:    op = stat.w_end ? OP_DOWN_START : OP_RD_W;
      S_RD_D:    if (!stat.w_end) op = OP_RD_W;
      S_EV_S:    op = stat.fit ? OP_SETUP_SMALL : OP_STEP_UP;
      S_EV_U:    op = stat.fit ? OP_SETUP_UP : OP_STEP_UP;
      S_EV_D:    op = stat.fit ? OP_SETUP_DOWN : OP_STEP_DOWN;
      S_G_DEC:   op = stat.split ? OP_PH_INIT : OP_G_NOSPLIT;
      S_PH:      op = OP_PH_STEP;
      S_G_T:     op = OP_G_T;
      S_G_W:     op = OP_G_W;
      S_NOSPACE: op = OP_NOSPACE;
      S_F_CHK:   op = stat.free_bad ? OP_F_OOB : OP_F_RD_H;
      S_F_EVH: begin
        if (!stat.mark) begin
          op = OP_F_NOTALLOC;
        end else if (stat.free) begin
          op = OP_F_DBL;
        end else begin
          op = OP_F_SET;
        end
      end
      S_F_Q:     if (stat.pv_ok) op = OP_F_RD_Q;
      S_F_EVQ:   if (stat.free) op = OP_F_MERGE_Q;
      S_F_N:     if (stat.nx_ok) op = OP_F_RD_N;
      S_F_EVN:   if (stat.free) op = OP_F_MERGE_N;
      default:   op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tefa_dp.sv =====
// Datapath of the allocator: header memories, walk pointers and result.
// Executes one operation from tefa_ctrl per cycle. Depends on tefa_pkg.
`default_nettype none
module tefa_dp #(
  parameter int ARENA_BYTES  = tefa_pkg::DEF_ARENA_BYTES,
  parameter int HEADER_BYTES = tefa_pkg::DEF_HEADER_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tefa_pkg::op_t     op,
  input  wire tefa_pkg::in_req_t in_data,
  input  wire logic              cfg_we,
  input  wire logic [11:0]       cfg_wdata,
  output tefa_pkg::stat_t        stat,
  output tefa_pkg::out_rsp_t     out_data
);
  import tefa_pkg::*;

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int LW = $clog2(ARENA_BYTES + 1);
  localparam int NW = LW + 1;
  localparam int CW = CALC_W;
  localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
  localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
  localparam logic [LW-1:0] NO_LINK = LW'(ARENA_BYTES);

  logic          mark_mem [ARENA_BYTES];
  logic [AW-1:0] size_mem [ARENA_BYTES];
  logic          free_mem [ARENA_BYTES];
  logic [LW-1:0] prev_mem [ARENA_BYTES];
  logic [LW-1:0] next_mem [ARENA_BYTES];

  logic          mark_rd_r, free_rd_r;
  logic [AW-1:0] size_rd_r;
  logic [LW-1:0] prev_rd_r, next_rd_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mark_we, size_we, free_we, prev_we, next_we;
  logic [AW-1:0] mark_wa, size_wa, free_wa, prev_wa, next_wa;
  logic          mark_wd, free_wd;
  logic [AW-1:0] size_wd;
  logic [LW-1:0] prev_wd, next_wd;

  logic [15:0]   x_r, x_nxt;
  logic          act_r, act_nxt;
  logic          ready_r, ready_nxt;
  logic [11:0]   thr_r;
  logic [AW-1:0] mid_r, mid_nxt;
  logic [LW-1:0] w_r, w_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] t_r, t_nxt;
  logic [AW-1:0] sz_r, sz_nxt;
  logic [LW-1:0] nx_r, nx_nxt;
  logic [LW-1:0] pv_r, pv_nxt;
  logic [AW-1:0] h_r, h_nxt;
  logic [AW-1:0] hs_r, hs_nxt;
  logic          hi_r, hi_nxt;
  logic          mvmid_r, mvmid_nxt;
  logic          split_r, split_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] lim_r, lim_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [15:0]   off_r, off_nxt;

  logic [CW-1:0] x_c, sz_c, w_c, t_c, t_low_c, t_high_c, lo_c, top_c, rd_sz_c;
  logic          nx_ok, rdn_ok, split_now;

  assign x_c      = CW'(x_r);
  assign sz_c     = CW'(sz_r);
  assign w_c      = CW'(w_r);
  assign t_c      = CW'(t_r);
  assign rd_sz_c  = CW'(size_rd_r);
  assign t_low_c  = w_c + HDR_C + x_c;
  assign t_high_c = w_c + rd_sz_c - x_c;
  assign lo_c     = (t_c >= HDR_C - CW'(1)) ? t_c - HDR_C + CW'(1) : '0;
  assign top_c    = (t_c + HDR_C < ARENA_C) ? t_c + HDR_C : ARENA_C;
  assign nx_ok    = CW'(nx_r) < ARENA_C;
  assign rdn_ok   = CW'(next_rd_r) < ARENA_C;
  assign split_now = rd_sz_c > x_c + HDR_C;

  always_comb begin
    stat.clr_last = (clr_r == AW'(ARENA_BYTES - 1));
    stat.ready    = ready_r;
    stat.act      = act_r;
    stat.is_small = x_c < CW'(thr_r);
    stat.w_end    = (w_c >= ARENA_C) || (CW'(cnt_r) > ARENA_C);
    stat.fit      = free_rd_r && (rd_sz_c >= x_c);
    stat.split    = split_r;
    stat.ph_last  = (clr_r == lim_r);
    stat.free_bad = !ready_r || (x_c < HDR_C) || (x_c > ARENA_C - CW'(1));
    stat.mark     = mark_rd_r;
    stat.free     = free_rd_r;
    stat.pv_ok    = CW'(pv_r) < ARENA_C;
    stat.nx_ok    = nx_ok;
  end

  assign out_data.status         = status_r;
  assign out_data.payload_offset = off_r;

  always_comb begin
    x_nxt = x_r;  act_nxt = act_r;  ready_nxt = ready_r;  mid_nxt = mid_r;
    w_nxt = w_r;  cnt_nxt = cnt_r;  t_nxt = t_r;  sz_nxt = sz_r;
    nx_nxt = nx_r;  pv_nxt = pv_r;  h_nxt = h_r;  hs_nxt = hs_r;
    hi_nxt = hi_r;  mvmid_nxt = mvmid_r;  split_nxt = split_r;
    clr_nxt = clr_r;  lim_nxt = lim_r;  status_nxt = status_r;  off_nxt = off_r;
    rd_en = 1'b0;  rd_addr = '0;
    mark_we = 1'b0;  mark_wa = '0;  mark_wd = 1'b0;
    size_we = 1'b0;  size_wa = '0;  size_wd = '0;
    free_we = 1'b0;  free_wa = '0;  free_wd = 1'b0;
    prev_we = 1'b0;  prev_wa = '0;  prev_wd = '0;
    next_we = 1'b0;  next_wa = '0;  next_wd = '0;
    case (op)
      OP_CLR_STEP: begin
        mark_we = 1'b1;
        mark_wa = clr_r;
        clr_nxt = clr_r + AW'(1);
      end
      OP_LATCH: begin
        x_nxt      = in_data.operand_value;
        act_nxt    = in_data.action;
        status_nxt = ST_OK;
        off_nxt    = '0;
      end
      OP_INIT_ARENA: begin
        mark_we = 1'b1;  mark_wd = 1'b1;
        size_we = 1'b1;  size_wd = AW'(ARENA_BYTES - HEADER_BYTES);
        free_we = 1'b1;  free_wd = 1'b1;
        prev_we = 1'b1;  prev_wd = NO_LINK;
        next_we = 1'b1;  next_wd = NO_LINK;
        mid_nxt   = '0;
        ready_nxt = 1'b1;
      end
      OP_SMALL_START: begin
        w_nxt   = '0;
        cnt_nxt = '0;
      end
      OP_RD_MID: begin
        rd_en   = 1'b1;
        rd_addr = mid_r;
      end
      OP_UP_START: begin
        w_nxt   = next_rd_r;
        cnt_nxt = '0;
      end
      OP_DOWN_START: begin
        w_nxt   = LW'(mid_r);
        cnt_nxt = '0;
      end
      OP_RD_W: begin
        rd_en   = 1'b1;
        rd_addr = w_r[AW-1:0];
        cnt_nxt = cnt_r + NW'(1);
      end
      OP_STEP_UP:   w_nxt = next_rd_r;
      OP_STEP_DOWN: w_nxt = prev_rd_r;
      OP_SETUP_SMALL, OP_SETUP_UP, OP_SETUP_DOWN: begin
        hi_nxt    = (op == OP_SETUP_DOWN);
        mvmid_nxt = (op == OP_SETUP_SMALL);
        split_nxt = split_now;
        sz_nxt    = size_rd_r;
        nx_nxt    = next_rd_r;
        t_nxt     = (op == OP_SETUP_DOWN) ? t_high_c[AW-1:0] : t_low_c[AW-1:0];
      end
      OP_PH_INIT: begin
        clr_nxt = lo_c[AW-1:0];
        lim_nxt = AW'(top_c - CW'(1));
      end
      OP_PH_STEP: begin
        // The new header gets its mark; marks it now overlaps are cleared.
        mark_we = 1'b1;
        mark_wa = clr_r;
        mark_wd = (clr_r == t_r);
        clr_nxt = clr_r + AW'(1);
      end
      OP_G_T: begin
        size_we = 1'b1;  size_wa = t_r;
        size_wd = hi_r ? x_r[AW-1:0] : AW'(sz_c - HDR_C - x_c);
        free_we = 1'b1;  free_wa = t_r;  free_wd = !hi_r;
        next_we = 1'b1;  next_wa = t_r;  next_wd = nx_r;
        prev_we = 1'b1;  prev_wa = t_r;  prev_wd = w_r;
      end
      OP_G_W: begin
        prev_we = nx_ok;  prev_wa = nx_r[AW-1:0];  prev_wd = LW'(t_r);
        next_we = 1'b1;   next_wa = w_r[AW-1:0];   next_wd = LW'(t_r);
        size_we = 1'b1;   size_wa = w_r[AW-1:0];
        size_wd = hi_r ? AW'(sz_c - x_c - HDR_C) : x_r[AW-1:0];
        free_we = 1'b1;   free_wa = w_r[AW-1:0];   free_wd = hi_r;
        if (!hi_r && mvmid_r && (w_c == CW'(mid_r))) mid_nxt = t_r;
        off_nxt = hi_r ? 16'(t_c + HDR_C) : 16'(w_c + HDR_C);
      end
      OP_G_NOSPLIT: begin
        free_we = 1'b1;
        free_wa = w_r[AW-1:0];
        off_nxt = 16'(w_c + HDR_C);
      end
      OP_NOSPACE: begin
        status_nxt = ST_NO_SPACE;
        off_nxt    = '0;
      end
      OP_F_OOB:      status_nxt = ST_OUT_BOUND;
      OP_F_NOTALLOC: status_nxt = ST_NOT_ALLOC;
      OP_F_DBL:      status_nxt = ST_DBL_FREE;
      OP_F_RD_H: begin
        h_nxt   = AW'(x_c - HDR_C);
        rd_en   = 1'b1;
        rd_addr = AW'(x_c - HDR_C);
      end
      OP_F_SET: begin
        free_we = 1'b1;  free_wa = h_r;  free_wd = 1'b1;
        pv_nxt  = prev_rd_r;
        nx_nxt  = next_rd_r;
        hs_nxt  = size_rd_r;
      end
      OP_F_RD_Q: begin
        rd_en   = 1'b1;
        rd_addr = pv_r[AW-1:0];
      end
      OP_F_MERGE_Q: begin
        // The freed block folds into its free predecessor.
        prev_we = nx_ok;  prev_wa = nx_r[AW-1:0];  prev_wd = pv_r;
        next_we = 1'b1;   next_wa = pv_r[AW-1:0];  next_wd = nx_r;
        size_we = 1'b1;   size_wa = pv_r[AW-1:0];
        size_wd = AW'(rd_sz_c + HDR_C + CW'(hs_r));
        hs_nxt  = AW'(rd_sz_c + HDR_C + CW'(hs_r));
        if (h_r == mid_r) mid_nxt = pv_r[AW-1:0];
        h_nxt   = pv_r[AW-1:0];
      end
      OP_F_RD_N: begin
        rd_en   = 1'b1;
        rd_addr = nx_r[AW-1:0];
      end
      OP_F_MERGE_N: begin
        prev_we = rdn_ok;  prev_wa = next_rd_r[AW-1:0];  prev_wd = LW'(h_r);
        next_we = 1'b1;    next_wa = h_r;                next_wd = next_rd_r;
        size_we = 1'b1;    size_wa = h_r;
        size_wd = AW'(CW'(hs_r) + HDR_C + rd_sz_c);
        if (CW'(nx_r) == CW'(mid_r)) mid_nxt = h_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      mid_r   <= '0;
      thr_r   <= THRESHOLD_RESET;
      clr_r   <= '0;
    end else begin
      ready_r <= ready_nxt;
      mid_r   <= mid_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;  act_r <= act_nxt;  w_r <= w_nxt;  cnt_r <= cnt_nxt;
    t_r <= t_nxt;  sz_r <= sz_nxt;  nx_r <= nx_nxt;  pv_r <= pv_nxt;
    h_r <= h_nxt;  hs_r <= hs_nxt;  hi_r <= hi_nxt;  mvmid_r <= mvmid_nxt;
    split_r <= split_nxt;  lim_r <= lim_nxt;
    status_r <= status_nxt;  off_r <= off_nxt;
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (rd_en) mark_rd_r <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    if (rd_en) size_rd_r <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    if (rd_en) free_rd_r <= free_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (rd_en) prev_rd_r <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (rd_en) next_rd_r <= next_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/two_ended_first_fit_allocator_top.sv =====
// Allocate walks the block list, then on a split rewrites the header marks around
// the new header; free checks the offset and merges with free neighbours. One request at
// a time; the result strobe comes in the cycle after the last datapath step, cannot
// be stalled, and the next request is taken in the cycle after the strobe.
// After reset a clearing pass wipes all ARENA_BYTES header marks;
// busy stays high during it. Synchronous active-low reset.
`default_nettype none
module two_ended_first_fit_allocator_top #(
  parameter int ARENA_BYTES  = tefa_pkg::DEF_ARENA_BYTES,
  parameter int HEADER_BYTES = tefa_pkg::DEF_HEADER_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire tefa_pkg::in_req_t  in_data,
  output logic                    out_valid,
  output tefa_pkg::out_rsp_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [11:0]        cfg_wdata
);
  import tefa_pkg::*;

  op_t   op;
  stat_t stat;

  tefa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tefa_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/tefa_checker.sv =====
// Port-level checks of the allocator top level, attached by bind.
// Depends on tefa_pkg and two_ended_first_fit_allocator_top_assert.svh.
`default_nettype none
`include "two_ended_first_fit_allocator_top_assert.svh"
module tefa_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire tefa_pkg::out_rsp_t out_data
);
  import tefa_pkg::*;

  // A result strobe lasts one cycle and the block is free again afterwards.
  `TEFA_ASSERT_ALWAYS(a_strobe_single, out_valid |=> !out_valid, "result strobe held")
  // The header clearing pass holds off requests right after reset.
  `TEFA_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> busy, "not busy after reset")
  `TEFA_ASSERT(a_fail_zero, (out_valid && out_data.status != ST_OK) |-> out_data.payload_offset == 16'd0, "failed request with offset")
  `TEFA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request not busy")

endmodule

bind two_ended_first_fit_allocator_top tefa_checker u_tefa_checker (.*);
`default_nettype wire
